// File: sv/tbgd_pkg.sv
`default_nettype none

package tbgd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned HoldW = 16;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW = HoldW;

  localparam logic [CfgIndexW-1:0] CFG_LONG_HOLD = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_BOTH_HOLD = 1'b1;

  localparam logic [HoldW-1:0] LONG_HOLD_RESET = 16'd1000;
  localparam logic [HoldW-1:0] BOTH_HOLD_RESET = 16'd3000;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             action_down;
    logic             mode_down;
  } sample_t;

  typedef struct packed {
    logic action_click;
    logic action_hold;
    logic mode_click;
    logic both_held;
  } result_t;

  typedef struct packed {
    logic [HoldW-1:0] long_hold_ms;
    logic [HoldW-1:0] both_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic             action_was_down;
    logic [TimeW-1:0] action_start;
    logic             action_hold_done;
    logic             mode_was_down;
    logic [TimeW-1:0] both_start;
    logic             both_timing;
    logic             both_done;
  } gesture_state_t;

  localparam gesture_state_t STATE_RESET = '{
    action_was_down:  1'b0,
    action_start:     '0,
    action_hold_done: 1'b0,
    mode_was_down:    1'b0,
    both_start:       '0,
    both_timing:      1'b0,
    both_done:        1'b0
  };

endpackage

`default_nettype wire

// File: sv/tbgd_ifs.sv
`default_nettype none

interface tbgd_in_if;
  logic                       valid;
  logic                       ready;
  logic [tbgd_pkg::TimeW-1:0] now_ms;
  logic                       action_down;
  logic                       mode_down;

  modport source (output valid, output now_ms, output action_down, output mode_down,
                  input ready);
  modport sink (input valid, input now_ms, input action_down, input mode_down,
                output ready);
endinterface

interface tbgd_out_if;
  logic valid;
  logic ready;
  logic action_click;
  logic action_hold;
  logic mode_click;
  logic both_held;

  modport source (output valid, output action_click, output action_hold,
                  output mode_click, output both_held, input ready);
  modport sink (input valid, input action_click, input action_hold,
                input mode_click, input both_held, output ready);
endinterface

`default_nettype wire

// File: sv/tbgd_cfg.sv
`default_nettype none

module tbgd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbgd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tbgd_pkg::CfgDataW-1:0]  cfg_data,
  output tbgd_pkg::cfg_t                cfg
);
  import tbgd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_hold_ms <= LONG_HOLD_RESET;
      cfg.both_hold_ms <= BOTH_HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_HOLD: cfg.long_hold_ms <= cfg_data;
        CFG_BOTH_HOLD: cfg.both_hold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/tbgd_step.sv
`default_nettype none

module tbgd_step (
  input  tbgd_pkg::sample_t        sample,
  input  tbgd_pkg::cfg_t           cfg,
  input  tbgd_pkg::gesture_state_t state,
  output tbgd_pkg::gesture_state_t state_next,
  output tbgd_pkg::result_t        result
);
  import tbgd_pkg::*;

  logic             a;
  logic             m;
  logic             both;
  logic [TimeW-1:0] action_elapsed;
  logic [TimeW-1:0] both_elapsed;

  assign a    = sample.action_down;
  assign m    = sample.mode_down;
  assign both = a & m;

  always_comb begin
    state_next = state;
    result     = '0;

    // both-held timer: stop when either button is up, clear the report when both are up
    if (!both) begin
      state_next.both_timing = 1'b0;
      if (!a && !m) begin
        state_next.both_done = 1'b0;
      end
    end else if (!state.both_timing) begin
      state_next.both_timing = 1'b1;
      state_next.both_start  = sample.now_ms;
    end

    action_elapsed = sample.now_ms - state.action_start;
    if (a && !state.action_was_down) begin
      state_next.action_was_down  = 1'b1;
      state_next.action_start     = sample.now_ms;
      state_next.action_hold_done = 1'b0;
    end else if (!a && state.action_was_down) begin
      state_next.action_was_down  = 1'b0;
      state_next.action_hold_done = 1'b0;
      result.action_click = !state.action_hold_done && !state.both_done && !m;
    end else if (state.action_was_down && !m && !state.action_hold_done &&
                 action_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.long_hold_ms}) begin
      state_next.action_hold_done = 1'b1;
      result.action_hold = 1'b1;
    end

    state_next.mode_was_down = m;
    result.mode_click = !m && state.mode_was_down && !state.both_done && !a;

    // timer may have started on this sample: elapsed is then zero
    both_elapsed = sample.now_ms - state_next.both_start;
    if (both && !state_next.both_done && state_next.both_timing &&
        both_elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.both_hold_ms}) begin
      state_next.both_done = 1'b1;
      result.both_held = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/two_button_gesture_detector.sv
// Two-button gesture detector. Each request on in_ch is one sample of a free-running
// millisecond timestamp and the pressed levels of the action and mode buttons; each
// sample yields exactly one result on out_ch with four event flags: action click on
// release, action long hold (once per press, mode up, after long_hold_ms), mode click on
// release, and both-held (once, after both_hold_ms with both down). Clicks are dropped
// while the other button is down or after a both-held report, action clicks also after a
// long hold. Throughput is one sample per clock while out_ch is ready; each accepted
// sample passes through the input register and then the result register, around the
// single step of compares and 32-bit subtractions. Write the two hold times through
// cfg_we/cfg_index/cfg_data only while no sample is in flight.
`default_nettype none

module two_button_gesture_detector (
  input  logic                           clk,
  input  logic                           rst,
  tbgd_in_if.sink                        in_ch,
  tbgd_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tbgd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tbgd_pkg::CfgDataW-1:0]  cfg_data
);
  import tbgd_pkg::*;

  cfg_t           cfg;
  sample_t        in_q;
  logic           in_full;
  result_t        out_q;
  logic           out_full;
  gesture_state_t state;
  gesture_state_t state_next;
  result_t        result;
  logic           advance;

  tbgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbgd_step u_step (
    .sample     (in_q),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  assign advance     = in_full && (!out_full || out_ch.ready);
  assign in_ch.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.now_ms      <= in_ch.now_ms;
      in_q.action_down <= in_ch.action_down;
      in_q.mode_down   <= in_ch.mode_down;
    end
  end

  // commit the state only when the result moves into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_RESET;
      out_full <= 1'b0;
    end else if (advance) begin
      state    <= state_next;
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_ch.valid        = out_full;
  assign out_ch.action_click = out_q.action_click;
  assign out_ch.action_hold  = out_q.action_hold;
  assign out_ch.mode_click   = out_q.mode_click;
  assign out_ch.both_held    = out_q.both_held;

endmodule

`default_nettype wire

// File: sv/tbgd_checker.sv
`default_nettype none

module tbgd_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic action_click,
  input logic action_hold,
  input logic mode_click,
  input logic both_held
);

  // no result may be offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({action_click, action_hold, mode_click, both_held}))
    else $error("stalled result changed");

  // a long hold needs the action button down, a click its release
  a_click_vs_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(action_click && action_hold))
    else $error("action click and long hold in one result");

  // both-held needs both buttons down: no click and no mode-up long hold with it
  a_both_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && both_held |-> !action_click && !mode_click && !action_hold)
    else $error("both-held reported with a click or long hold");

endmodule

bind two_button_gesture_detector tbgd_checker u_tbgd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .action_click (out_ch.action_click),
  .action_hold  (out_ch.action_hold),
  .mode_click   (out_ch.mode_click),
  .both_held    (out_ch.both_held)
);

`default_nettype wire

// File: tb/gesture_flag_checker.sv
`default_nettype none

module gesture_flag_checker (
  input  logic                           clk,
  input  logic                           rst,
  tbgd_in_if                             in_ch,
  tbgd_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [tbgd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tbgd_pkg::CfgDataW-1:0]  cfg_data,
  output int                             mismatch_count,
  output int                             flags_in_flight
);
  import tbgd_pkg::*;

  cfg_t           holds;
  gesture_state_t st;
  result_t        expected_flags[$];

  // Advance the button state by one sample and return the event flags it raises.
  function automatic result_t step_gesture(input sample_t s);
    result_t          r;
    logic             both;
    logic             prior_both_done;
    logic [TimeW-1:0] a_elapsed;
    logic [TimeW-1:0] b_elapsed;
    r = '0;
    both = s.action_down & s.mode_down;
    // clicks see the both-held report as it stood before this sample
    prior_both_done = st.both_done;

    if (!both) begin
      st.both_timing = 1'b0;
      if (!s.action_down && !s.mode_down) begin
        st.both_done = 1'b0;
      end
    end else if (!st.both_timing) begin
      st.both_timing = 1'b1;
      st.both_start  = s.now_ms;
    end

    a_elapsed = s.now_ms - st.action_start;
    if (s.action_down && !st.action_was_down) begin
      st.action_was_down  = 1'b1;
      st.action_start     = s.now_ms;
      st.action_hold_done = 1'b0;
    end else if (!s.action_down && st.action_was_down) begin
      st.action_was_down  = 1'b0;
      r.action_click      = !st.action_hold_done && !prior_both_done && !s.mode_down;
      st.action_hold_done = 1'b0;
    end else if (st.action_was_down && !s.mode_down && !st.action_hold_done &&
                 a_elapsed >= {{(TimeW-HoldW){1'b0}}, holds.long_hold_ms}) begin
      st.action_hold_done = 1'b1;
      r.action_hold       = 1'b1;
    end

    if (s.mode_down && !st.mode_was_down) begin
      st.mode_was_down = 1'b1;
    end else if (!s.mode_down && st.mode_was_down) begin
      st.mode_was_down = 1'b0;
      r.mode_click     = !prior_both_done && !s.action_down;
    end

    b_elapsed = s.now_ms - st.both_start;
    if (both && !st.both_done && st.both_timing &&
        b_elapsed >= {{(TimeW-HoldW){1'b0}}, holds.both_hold_ms}) begin
      st.both_done = 1'b1;
      r.both_held  = 1'b1;
    end
    return r;
  endfunction

  task automatic compare_flags(input result_t got);
    result_t want;
    if (expected_flags.size() == 0) begin
      $error("result with no sample waiting: flags %b", got);
      mismatch_count++;
    end else begin
      want = expected_flags.pop_front();
      if (got.action_click !== want.action_click) begin
        $error("action_click: expected %0b, got %0b", want.action_click, got.action_click);
        mismatch_count++;
      end
      if (got.action_hold !== want.action_hold) begin
        $error("action_hold: expected %0b, got %0b", want.action_hold, got.action_hold);
        mismatch_count++;
      end
      if (got.mode_click !== want.mode_click) begin
        $error("mode_click: expected %0b, got %0b", want.mode_click, got.mode_click);
        mismatch_count++;
      end
      if (got.both_held !== want.both_held) begin
        $error("both_held: expected %0b, got %0b", want.both_held, got.both_held);
        mismatch_count++;
      end
    end
  endtask

  initial begin
    mismatch_count  = 0;
    flags_in_flight = 0;
  end

  always @(posedge clk) begin
    sample_t s;
    result_t got;
    if (rst) begin
      holds.long_hold_ms = LONG_HOLD_RESET;
      holds.both_hold_ms = BOTH_HOLD_RESET;
      st = STATE_RESET;
      expected_flags.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_LONG_HOLD: holds.long_hold_ms = cfg_data;
          CFG_BOTH_HOLD: holds.both_hold_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        s.now_ms      = in_ch.now_ms;
        s.action_down = in_ch.action_down;
        s.mode_down   = in_ch.mode_down;
        expected_flags.push_back(step_gesture(s));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.action_click = out_ch.action_click;
        got.action_hold  = out_ch.action_hold;
        got.mode_click   = out_ch.mode_click;
        got.both_held    = out_ch.both_held;
        compare_flags(got);
      end
    end
    flags_in_flight = expected_flags.size();
  end

endmodule

`default_nettype wire

// File: tb/two_button_gesture_detector_tb.sv
`default_nettype none

module two_button_gesture_detector_tb;
  import tbgd_pkg::*;

  localparam int CycleLimit = 200000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  int                   mismatch_count;
  int                   flags_in_flight;

  // no random gaps on either side while set
  bit                   quiet;
  logic [TimeW-1:0]     clock_ms;
  logic [HoldW-1:0]     long_hold;
  logic [HoldW-1:0]     both_hold;

  tbgd_in_if  in_ch();
  tbgd_out_if out_ch();

  two_button_gesture_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gesture_flag_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .flags_in_flight (flags_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 19);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("two_button_gesture_detector verification failed");
    $finish;
  end

  task automatic send_sample(input logic [TimeW-1:0] t, input logic a, input logic m);
    while (!quiet && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.now_ms      <= t;
    in_ch.action_down <= a;
    in_ch.mode_down   <= m;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (flags_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both hold times; only called with the pipeline drained.
  task automatic set_holds(input logic [HoldW-1:0] lh, input logic [HoldW-1:0] bh);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_HOLD;
    cfg_data  <= lh;
    @(negedge clk);
    cfg_index <= CFG_BOTH_HOLD;
    cfg_data  <= bh;
    @(negedge clk);
    cfg_we    <= 1'b0;
    long_hold = lh;
    both_hold = bh;
    @(negedge clk);
  endtask

  // Runs of held button patterns with time steps scaled to the hold times,
  // plus the odd jump to an arbitrary timestamp.
  task automatic run_presses(input int count);
    int   sent;
    int   run_len;
    int   pick;
    logic a;
    logic m;
    sent = 0;
    while (sent < count) begin
      a = 1'($urandom_range(1));
      m = 1'($urandom_range(1));
      run_len = int'($urandom_range(5, 1));
      for (int k = 0; k < run_len && sent < count; k++) begin
        pick = int'($urandom_range(99));
        if (pick < 4) begin
          clock_ms = $urandom;
          send_sample(clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          if (pick < 35) begin
            clock_ms = clock_ms + $urandom_range(3);
          end else if (pick < 70) begin
            clock_ms = clock_ms + $urandom_range(int'(long_hold) / 2 + 1);
          end else if (pick < 95) begin
            clock_ms = clock_ms + $urandom_range(int'(both_hold) / 2 + 1);
          end else begin
            clock_ms = clock_ms + $urandom_range(200000);
          end
          send_sample(clock_ms, a, m);
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_LONG_HOLD;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.now_ms      = '0;
    in_ch.action_down = 1'b0;
    in_ch.mode_down   = 1'b0;
    out_ch.ready      = 1'b0;
    quiet             = 1'b0;
    clock_ms          = '0;
    long_hold         = LONG_HOLD_RESET;
    both_hold         = BOTH_HOLD_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // both held from timestamp zero, released mode first then action
    send_sample(32'd0, 1'b0, 1'b0);
    send_sample(32'd0, 1'b1, 1'b1);
    send_sample(32'd2999, 1'b1, 1'b1);
    send_sample(32'd3000, 1'b1, 1'b1);
    send_sample(32'd3100, 1'b1, 1'b0);
    send_sample(32'd3200, 1'b0, 1'b0);
    // long hold at the exact threshold, then no click on release
    send_sample(32'd3300, 1'b1, 1'b0);
    send_sample(32'd4299, 1'b1, 1'b0);
    send_sample(32'd4300, 1'b1, 1'b0);
    send_sample(32'd4400, 1'b0, 1'b0);
    // plain clicks
    send_sample(32'd4500, 1'b1, 1'b0);
    send_sample(32'd4600, 1'b0, 1'b0);
    send_sample(32'd4700, 1'b0, 1'b1);
    send_sample(32'd4800, 1'b0, 1'b0);
    // mode released under action: dropped; action released alone: click
    send_sample(32'd4900, 1'b1, 1'b0);
    send_sample(32'd5000, 1'b1, 1'b1);
    send_sample(32'd5100, 1'b1, 1'b0);
    send_sample(32'd5200, 1'b0, 1'b0);
    // long hold across the timestamp wrap
    send_sample(32'hFFFF_FF00, 1'b1, 1'b0);
    send_sample(32'h0000_02E7, 1'b1, 1'b0);
    send_sample(32'h0000_02E8, 1'b1, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    drain();

    set_holds('0, '0);
    run_presses(120);
    drain();

    set_holds('1, '1);
    run_presses(120);
    drain();

    quiet = 1'b1;
    set_holds(16'd3, 16'd5);
    run_presses(150);
    drain();
    quiet = 1'b0;

    set_holds(HoldW'($urandom), HoldW'($urandom));
    run_presses(150);
    drain();

    set_holds(HoldW'($urandom_range(50)), HoldW'($urandom_range(80)));
    run_presses(160);
    drain();

    if (mismatch_count == 0 && flags_in_flight == 0) begin
      $display("two_button_gesture_detector verification clean");
    end else begin
      $display("two_button_gesture_detector verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/tbgd_pkg.sv
sv/tbgd_ifs.sv
sv/tbgd_cfg.sv
sv/tbgd_step.sv
sv/two_button_gesture_detector.sv
sv/tbgd_checker.sv
tb/gesture_flag_checker.sv
tb/two_button_gesture_detector_tb.sv
